### sv/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// shared types, round constants and sigma functions of the sha-256 hasher
// ----------------------------------------------------------------------------
package sha256_pkg;

  // command codes of an input beat
  localparam logic CmdAbsorb = 1'b0;
  localparam logic CmdFinish = 1'b1;

  // first padding byte
  localparam logic [7:0] PadMarker = 8'h80;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // control of the round unit
  typedef struct packed {
    logic init;   // hash words back to initial values
    logic load;   // working variables from hash words
    logic round;  // one compression round
    logic fold;   // add working variables into hash words
  } sha256_core_ctrl_t;

  // control of the message window
  typedef struct packed {
    logic       shift;  // take one byte in
    logic [7:0] data;   // byte to take in
    logic       step;   // advance the schedule by one word
  } sha256_sched_ctrl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### sv/sha256_sched.sv
// ----------------------------------------------------------------------------
// sha256_sched
// 16-word message window: bytes shift in, then one schedule word per round
// ----------------------------------------------------------------------------
module sha256_sched import sha256_pkg::*; (
  input  logic               clk_i,
  input  sha256_sched_ctrl_t ctrl_i,
  output logic [31:0]        w_o
);

  logic [511:0] win_q, win_d;
  logic [31:0]  new_word;

  // word j of the window sits at bits 511-32j downwards
  assign new_word = small_sigma1(win_q[511-32*14 -: 32]) + win_q[511-32*9 -: 32]
                  + small_sigma0(win_q[511-32*1 -: 32]) + win_q[511 -: 32];

  assign w_o = win_q[511 -: 32];

  always_comb begin
    win_d = win_q;
    if (ctrl_i.shift) begin
      win_d = {win_q[503:0], ctrl_i.data};
    end else if (ctrl_i.step) begin
      win_d = {win_q[479:0], new_word};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

### sv/sha256_core.sv
// ----------------------------------------------------------------------------
// sha256_core
// hash words and the shared compression round, one round per cycle
// ----------------------------------------------------------------------------
module sha256_core import sha256_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha256_core_ctrl_t ctrl_i,
  input  logic [31:0]       w_i,
  input  logic [5:0]        round_i,
  input  logic [2:0]        word_sel_i,
  output logic [31:0]       word_o
);

  logic [31:0] hash_q [8];
  logic [31:0] hash_d [8];
  logic [31:0] work_q [8];
  logic [31:0] work_d [8];
  logic [31:0] t1, t2;

  assign t1 = work_q[7] + big_sigma1(work_q[4])
            + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
            + RoundK[round_i] + w_i;
  assign t2 = big_sigma0(work_q[0])
            + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

  always_comb begin
    work_d = work_q;
    hash_d = hash_q;
    if (ctrl_i.load) begin
      work_d = hash_q;
    end else if (ctrl_i.round) begin
      work_d[7] = work_q[6];
      work_d[6] = work_q[5];
      work_d[5] = work_q[4];
      work_d[4] = work_q[3] + t1;
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[0];
      work_d[0] = t1 + t2;
    end
    if (ctrl_i.init) begin
      hash_d = InitH;
    end else if (ctrl_i.fold) begin
      for (int j = 0; j < 8; j++) begin
        hash_d[j] = hash_q[j] + work_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= InitH;
    end else begin
      hash_q <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign word_o = hash_q[word_sel_i];

endmodule

### sv/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// byte-serial sha-256: absorbs message bytes, pads on finish, emits 8 words
// ----------------------------------------------------------------------------
// input: an absorb beat that does not fill a block is taken without a stall; the
//   beat that fills a block stalls the input during load, 64 rounds on the shared
//   round unit and fold, so no byte is taken until that block is folded
// finish: padding bytes fill each padding block, which is then compressed, then
//   8 output beats
// reset: hash words return to the initial values, byte count and fill clear
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_FOLD  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [5:0]         fill_q, fill_d;       // byte position in the block
  logic [60:0]        count_q, count_d;     // message bytes, wraps
  logic [5:0]         rnd_q, rnd_d;
  logic [2:0]         idx_q, idx_d;
  logic               pad_q, pad_d;         // finishing the message
  logic               pad80_q, pad80_d;     // marker byte still to go in
  logic               len_ok_q, len_ok_d;   // this block carries the length

  logic               in_acc, out_acc;
  logic [63:0]        bit_len, len_shift;
  logic [7:0]         pad_byte;
  sha256_core_ctrl_t  core_ctrl;
  sha256_sched_ctrl_t sched_ctrl;
  logic [31:0]        sched_w;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;

  // length bytes go in big-endian: byte k of the tail is bits 63-8k downwards
  assign bit_len   = {count_q, 3'b000};
  assign len_shift = bit_len >> {~fill_q[2:0], 3'b000};

  always_comb begin
    if (pad80_q) begin
      pad_byte = PadMarker;
    end else if (len_ok_q && (fill_q >= 6'd56)) begin
      pad_byte = len_shift[7:0];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    count_d    = count_q;
    rnd_d      = rnd_q;
    idx_d      = idx_q;
    pad_d      = pad_q;
    pad80_d    = pad80_q;
    len_ok_d   = len_ok_q;
    core_ctrl  = '0;
    sched_ctrl = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i == CmdAbsorb) begin
            sched_ctrl.shift = 1'b1;
            sched_ctrl.data  = data_byte_i;
            fill_d  = fill_q + 6'd1;
            count_d = count_q + 61'd1;
            if (fill_q == 6'd63) begin
              state_d = ST_LOAD;
            end
          end else begin
            // length fits behind the marker only up to 55 pending bytes
            pad_d    = 1'b1;
            pad80_d  = 1'b1;
            len_ok_d = (fill_q <= 6'd55);
            state_d  = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        sched_ctrl.shift = 1'b1;
        sched_ctrl.data  = pad_byte;
        pad80_d = 1'b0;
        fill_d  = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        core_ctrl.load = 1'b1;
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        core_ctrl.round = 1'b1;
        sched_ctrl.step = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        core_ctrl.fold = 1'b1;
        if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (len_ok_q) begin
          idx_d   = '0;
          state_d = ST_OUT;
        end else begin
          // extra block: zeros then the length
          len_ok_d = 1'b1;
          state_d  = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            core_ctrl.init = 1'b1;
            count_d  = '0;
            fill_d   = '0;
            pad_d    = 1'b0;
            len_ok_d = 1'b0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      count_q  <= '0;
      rnd_q    <= '0;
      idx_q    <= '0;
      pad_q    <= 1'b0;
      pad80_q  <= 1'b0;
      len_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      count_q  <= count_d;
      rnd_q    <= rnd_d;
      idx_q    <= idx_d;
      pad_q    <= pad_d;
      pad80_q  <= pad80_d;
      len_ok_q <= len_ok_d;
    end
  end

  sha256_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (sched_w)
  );

  sha256_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (core_ctrl),
    .w_i        (sched_w),
    .round_i    (rnd_q),
    .word_sel_i (idx_q),
    .word_o     (digest_word_o)
  );

  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == 3'd7);

  // a byte that fills the block starts a compression
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i == CmdAbsorb) && (fill_q == 6'd63)) |=> (state_q == ST_LOAD))
    else $error("full block did not start compression");

  // the round loop ends after exactly 64 rounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_FOLD))
    else $error("round loop did not end at round 63");

  // digest words only come out after the length block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (len_ok_q && pad_q && !pad80_q && fill_q == 6'd0))
    else $error("digest output before padding completed");

  // the final beat leaves the hasher cleared for a new message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_word_o) |=> (state_q == ST_IDLE && count_q == '0 && !pad_q))
    else $error("hasher not cleared after digest");

endmodule
